/* src/atc_pkg.sv */
// Package for the altitude thrust controller: word format, configuration
// struct, sequencer states and the saturating fixed-point helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package atc_pkg;

    localparam int WORD_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_WIDTH = 2 * WORD_WIDTH;
    localparam int MAG_WIDTH  = PROD_WIDTH - FRAC_BITS;
    localparam int CFG_WIDTH  = WORD_WIDTH - 1;
    localparam int TILT_WIDTH = 18;
    localparam int DT_WIDTH   = 17;
    localparam int DIV_WIDTH  = 17;
    localparam int DIV_CYCLES = PROD_WIDTH / 2;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);
    localparam int ADDR_WIDTH = 5;
    localparam int DATA_WIDTH = 32;

    localparam logic signed [WORD_WIDTH-1:0] GRAVITY_SCALED = WORD_WIDTH'(642908);

    localparam logic [CFG_WIDTH-1:0] RST_GAIN          = '0;
    localparam logic [CFG_WIDTH-1:0] RST_MASS          = CFG_WIDTH'(65536);
    localparam logic [CFG_WIDTH-1:0] RST_RATE_LIMIT    = CFG_WIDTH'(6553600);
    localparam logic [CFG_WIDTH-1:0] RST_THRUST_FLOOR  = CFG_WIDTH'(2621440);
    localparam logic [CFG_WIDTH-1:0] RST_THRUST_CEIL   = CFG_WIDTH'(23592960);

    typedef enum logic [2:0] {
        REG_GAIN_POSITION  = 3'd0,
        REG_GAIN_VELOCITY  = 3'd1,
        REG_GAIN_INTEGRAL  = 3'd2,
        REG_VEHICLE_MASS   = 3'd3,
        REG_DESCENT_LIMIT  = 3'd4,
        REG_ASCENT_LIMIT   = 3'd5,
        REG_THRUST_FLOOR   = 3'd6,
        REG_THRUST_CEILING = 3'd7
    } atc_reg_idx_t;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] gain_position;
        logic [CFG_WIDTH-1:0] gain_velocity;
        logic [CFG_WIDTH-1:0] gain_integral;
        logic [CFG_WIDTH-1:0] vehicle_mass;
        logic [CFG_WIDTH-1:0] descent_rate_limit;
        logic [CFG_WIDTH-1:0] ascent_rate_limit;
        logic [CFG_WIDTH-1:0] thrust_floor;
        logic [CFG_WIDTH-1:0] thrust_ceiling;
    } atc_cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ZERR,
        ST_VERR,
        ST_MUL_D,
        ST_MUL_I,
        ST_ADD_FF,
        ST_SUM,
        ST_MUL_G,
        ST_ADD_I,
        ST_GRAV,
        ST_NEG,
        ST_MUL_M,
        ST_DIV,
        ST_DONE
    } atc_state_t;

    function automatic logic signed [WORD_WIDTH-1:0] sat_addsub(
        input logic signed [WORD_WIDTH-1:0] a,
        input logic signed [WORD_WIDTH-1:0] b,
        input logic                         sub
    );
        logic [WORD_WIDTH:0] s;
        logic signed [WORD_WIDTH-1:0] r;
        if (sub) begin
            s = {a[WORD_WIDTH-1], a} - {b[WORD_WIDTH-1], b};
        end else begin
            s = {a[WORD_WIDTH-1], a} + {b[WORD_WIDTH-1], b};
        end
        if (s[WORD_WIDTH] != s[WORD_WIDTH-1]) begin
            r = s[WORD_WIDTH] ? {1'b1, {(WORD_WIDTH-1){1'b0}}}
                              : {1'b0, {(WORD_WIDTH-1){1'b1}}};
        end else begin
            r = s[WORD_WIDTH-1:0];
        end
        return r;
    endfunction

    function automatic logic [WORD_WIDTH-1:0] mag_of(input logic signed [WORD_WIDTH-1:0] x);
        logic [WORD_WIDTH-1:0] r;
        r = x[WORD_WIDTH-1] ? WORD_WIDTH'(-x) : x;
        return r;
    endfunction

    function automatic logic signed [WORD_WIDTH-1:0] qfix(
        input logic [PROD_WIDTH-1:0] prod,
        input logic                  neg
    );
        logic [MAG_WIDTH-1:0]  m;
        logic [MAG_WIDTH-1:0]  lim;
        logic [WORD_WIDTH-1:0] mw;
        m   = prod[PROD_WIDTH-1:FRAC_BITS];
        lim = neg ? {{(MAG_WIDTH-WORD_WIDTH){1'b0}}, 1'b1, {(WORD_WIDTH-1){1'b0}}}
                  : {{(MAG_WIDTH-WORD_WIDTH+1){1'b0}}, {(WORD_WIDTH-1){1'b1}}};
        if (m > lim) begin
            m = lim;
        end
        mw = m[WORD_WIDTH-1:0];
        return neg ? WORD_WIDTH'(-mw) : mw;
    endfunction

endpackage

`default_nettype wire

/* src/atc_cfg_regs.sv */
// Configuration register file of the altitude thrust controller, APB-style.
// Depends on atc_pkg for the register map and the configuration struct.
`timescale 1ns / 1ps
`default_nettype none

module atc_cfg_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [atc_pkg::ADDR_WIDTH-1:0] paddr,
    input  wire logic [atc_pkg::DATA_WIDTH-1:0] pwdata,
    output logic      [atc_pkg::DATA_WIDTH-1:0] prdata,
    output logic                               pready,
    output atc_pkg::atc_cfg_t                  cfg
);
    import atc_pkg::*;

    atc_cfg_t             cfg_reg;
    atc_cfg_t             cfg_next;
    atc_reg_idx_t         idx;
    logic [CFG_WIDTH-1:0] wval;
    logic [CFG_WIDTH-1:0] rval;

    assign idx    = atc_reg_idx_t'(paddr[ADDR_WIDTH-1:2]);
    assign wval   = pwdata[CFG_WIDTH-1:0];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;
    assign prdata = {{(DATA_WIDTH-CFG_WIDTH){1'b0}}, rval};

    always_comb begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite) begin
            case (idx)
                REG_GAIN_POSITION:  cfg_next.gain_position      = wval;
                REG_GAIN_VELOCITY:  cfg_next.gain_velocity      = wval;
                REG_GAIN_INTEGRAL:  cfg_next.gain_integral      = wval;
                REG_VEHICLE_MASS:   cfg_next.vehicle_mass       = wval;
                REG_DESCENT_LIMIT:  cfg_next.descent_rate_limit = wval;
                REG_ASCENT_LIMIT:   cfg_next.ascent_rate_limit  = wval;
                REG_THRUST_FLOOR:   cfg_next.thrust_floor       = wval;
                REG_THRUST_CEILING: cfg_next.thrust_ceiling     = wval;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_GAIN_POSITION:  rval = cfg_reg.gain_position;
            REG_GAIN_VELOCITY:  rval = cfg_reg.gain_velocity;
            REG_GAIN_INTEGRAL:  rval = cfg_reg.gain_integral;
            REG_VEHICLE_MASS:   rval = cfg_reg.vehicle_mass;
            REG_DESCENT_LIMIT:  rval = cfg_reg.descent_rate_limit;
            REG_ASCENT_LIMIT:   rval = cfg_reg.ascent_rate_limit;
            REG_THRUST_FLOOR:   rval = cfg_reg.thrust_floor;
            REG_THRUST_CEILING: rval = cfg_reg.thrust_ceiling;
            default:            rval = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_position      <= RST_GAIN;
            cfg_reg.gain_velocity      <= RST_GAIN;
            cfg_reg.gain_integral      <= RST_GAIN;
            cfg_reg.vehicle_mass       <= RST_MASS;
            cfg_reg.descent_rate_limit <= RST_RATE_LIMIT;
            cfg_reg.ascent_rate_limit  <= RST_RATE_LIMIT;
            cfg_reg.thrust_floor       <= RST_THRUST_FLOOR;
            cfg_reg.thrust_ceiling     <= RST_THRUST_CEIL;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

/* src/altitude_thrust_controller.sv */
// Top level of the altitude thrust controller: sequencer around one shared
// saturating adder, one 32x32 multiplier and a radix-4 restoring divider.
// Depends on atc_pkg and atc_cfg_regs.
//
//  channel  direction  handshake            payload
//  s_       in         s_valid / s_ready    targets, measurements, feedforward, tilt, time step
//  m_       out        m_valid / m_ready    collective thrust, limit flag
//  apb      in         psel/penable/pready  eight 31-bit registers at 4*i
//
// With positive tilt cosine an item ends in the divider loop (two quotient bits
// a cycle) behind eleven adder and multiplier steps; otherwise the loop is
// skipped. s_ready is high only in the idle state.
// Reset clears the sequencer, the output valid and the error integrator.
// A result that m_ready does not take holds the sequencer in its last step.
`timescale 1ns / 1ps
`default_nettype none

module altitude_thrust_controller (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [atc_pkg::ADDR_WIDTH-1:0]  paddr,
    input  wire logic [atc_pkg::DATA_WIDTH-1:0]  pwdata,
    output logic      [atc_pkg::DATA_WIDTH-1:0]  prdata,
    output logic                                 pready,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic signed [31:0]              s_position_target,
    input  wire logic signed [31:0]              s_velocity_target,
    input  wire logic signed [31:0]              s_position_measured,
    input  wire logic signed [31:0]              s_velocity_measured,
    input  wire logic signed [31:0]              s_accel_feedforward,
    input  wire logic signed [atc_pkg::TILT_WIDTH-1:0] s_tilt_cosine,
    input  wire logic [atc_pkg::DT_WIDTH-1:0]    s_time_step,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [atc_pkg::CFG_WIDTH-1:0]        m_collective_thrust,
    output logic                                 m_thrust_limited
);
    import atc_pkg::*;

    atc_cfg_t cfg;

    atc_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    atc_state_t state_reg, state_next;

    logic signed [WORD_WIDTH-1:0] pos_t_reg, pos_t_next;
    logic signed [WORD_WIDTH-1:0] vel_reg, vel_next;
    logic signed [WORD_WIDTH-1:0] pos_m_reg, pos_m_next;
    logic signed [WORD_WIDTH-1:0] vel_m_reg, vel_m_next;
    logic signed [WORD_WIDTH-1:0] acc_ff_reg, acc_ff_next;
    logic signed [TILT_WIDTH-1:0] tilt_reg, tilt_next;
    logic [DT_WIDTH-1:0]          dt_reg, dt_next;
    logic signed [WORD_WIDTH-1:0] zerr_reg, zerr_next;
    logic signed [WORD_WIDTH-1:0] verr_reg, verr_next;
    logic signed [WORD_WIDTH-1:0] acc_reg, acc_next;
    logic signed [WORD_WIDTH-1:0] sum_reg, sum_next;
    logic [PROD_WIDTH-1:0]        prod_reg, prod_next;
    logic                         neg_reg, neg_next;
    logic [DIV_WIDTH-1:0]         rem_reg, rem_next;
    logic [DIV_CNT_W-1:0]         cnt_reg, cnt_next;
    logic                         m_valid_reg, m_valid_next;
    logic [CFG_WIDTH-1:0]         thrust_reg, thrust_next;
    logic                         limited_reg, limited_next;

    logic signed [WORD_WIDTH-1:0] add_a, add_b, add_y;
    logic                         add_sub;
    logic [WORD_WIDTH-1:0]        mul_a, mul_b;
    logic [PROD_WIDTH-1:0]        mul_y;
    logic                         mul_neg;
    logic signed [WORD_WIDTH-1:0] q_val;

    logic signed [WORD_WIDTH-1:0] lo_v, hi_v;
    logic [DIV_WIDTH-1:0]         divisor;
    logic [DIV_WIDTH:0]           t1, t2;
    logic [DIV_WIDTH-1:0]         r1, r2;
    logic                         qb1, qb2;
    logic                         tilt_nonpos;
    logic                         positive;
    logic signed [PROD_WIDTH-1:0] thrust_s, lo_s, hi_s;
    logic [CFG_WIDTH-1:0]         res_thrust;
    logic                         res_limited;

    assign s_ready             = (state_reg == ST_IDLE);
    assign m_valid             = m_valid_reg;
    assign m_collective_thrust = thrust_reg;
    assign m_thrust_limited    = limited_reg;

    assign add_y = sat_addsub(add_a, add_b, add_sub);
    assign mul_y = mul_a * mul_b;
    assign q_val = qfix(prod_reg, neg_reg);

    assign lo_v = WORD_WIDTH'(-$signed({1'b0, cfg.descent_rate_limit}));
    assign hi_v = $signed({1'b0, cfg.ascent_rate_limit});

    assign divisor = tilt_reg[DIV_WIDTH-1:0];
    assign t1  = {rem_reg, prod_reg[PROD_WIDTH-1]};
    assign qb1 = (t1 >= {1'b0, divisor});
    assign r1  = qb1 ? DIV_WIDTH'(t1 - {1'b0, divisor}) : t1[DIV_WIDTH-1:0];
    assign t2  = {r1, prod_reg[PROD_WIDTH-2]};
    assign qb2 = (t2 >= {1'b0, divisor});
    assign r2  = qb2 ? DIV_WIDTH'(t2 - {1'b0, divisor}) : t2[DIV_WIDTH-1:0];

    assign tilt_nonpos = tilt_reg[TILT_WIDTH-1] || (tilt_reg == '0);
    assign thrust_s    = neg_reg ? -$signed(prod_reg) : $signed(prod_reg);
    assign lo_s        = $signed({{(PROD_WIDTH-CFG_WIDTH){1'b0}}, cfg.thrust_floor});
    assign hi_s        = $signed({{(PROD_WIDTH-CFG_WIDTH){1'b0}}, cfg.thrust_ceiling});

    always_comb begin
        if ((cfg.vehicle_mass == '0) || (acc_reg == '0)) begin
            positive = 1'b0;
        end else if (tilt_reg == '0) begin
            positive = !acc_reg[WORD_WIDTH-1];
        end else begin
            positive = acc_reg[WORD_WIDTH-1];
        end
        if (tilt_nonpos) begin
            res_thrust  = positive ? cfg.thrust_ceiling : cfg.thrust_floor;
            res_limited = 1'b1;
        end else if (thrust_s < lo_s) begin
            res_thrust  = cfg.thrust_floor;
            res_limited = 1'b1;
        end else if (thrust_s > hi_s) begin
            res_thrust  = cfg.thrust_ceiling;
            res_limited = 1'b1;
        end else begin
            res_thrust  = thrust_s[CFG_WIDTH-1:0];
            res_limited = 1'b0;
        end
    end

    always_comb begin
        add_a   = acc_reg;
        add_b   = '0;
        add_sub = 1'b0;
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = neg_reg;
        case (state_reg)
            ST_ZERR: begin
                add_a   = pos_t_reg;
                add_b   = pos_m_reg;
                add_sub = 1'b1;
            end
            ST_VERR: begin
                add_a   = vel_reg;
                add_b   = vel_m_reg;
                add_sub = 1'b1;
                mul_a   = {1'b0, cfg.gain_position};
                mul_b   = mag_of(zerr_reg);
                mul_neg = zerr_reg[WORD_WIDTH-1];
            end
            ST_MUL_D: begin
                add_b   = q_val;
                mul_a   = {1'b0, cfg.gain_velocity};
                mul_b   = mag_of(verr_reg);
                mul_neg = verr_reg[WORD_WIDTH-1];
            end
            ST_MUL_I: begin
                add_b   = q_val;
                mul_a   = mag_of(zerr_reg);
                mul_b   = {{(WORD_WIDTH-DT_WIDTH){1'b0}}, dt_reg};
                mul_neg = zerr_reg[WORD_WIDTH-1];
            end
            ST_ADD_FF: begin
                add_b = acc_ff_reg;
            end
            ST_SUM: begin
                add_a = sum_reg;
                add_b = q_val;
            end
            ST_MUL_G: begin
                mul_a   = {1'b0, cfg.gain_integral};
                mul_b   = mag_of(sum_reg);
                mul_neg = sum_reg[WORD_WIDTH-1];
            end
            ST_ADD_I: begin
                add_b = q_val;
            end
            ST_GRAV: begin
                add_b   = GRAVITY_SCALED;
                add_sub = 1'b1;
            end
            ST_NEG: begin
                add_a   = '0;
                add_b   = acc_reg;
                add_sub = 1'b1;
            end
            ST_MUL_M: begin
                mul_a   = {1'b0, cfg.vehicle_mass};
                mul_b   = mag_of(acc_reg);
                mul_neg = acc_reg[WORD_WIDTH-1];
            end
            default: begin
                add_a = acc_reg;
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        pos_t_next   = pos_t_reg;
        vel_next     = vel_reg;
        pos_m_next   = pos_m_reg;
        vel_m_next   = vel_m_reg;
        acc_ff_next  = acc_ff_reg;
        tilt_next    = tilt_reg;
        dt_next      = dt_reg;
        zerr_next    = zerr_reg;
        verr_next    = verr_reg;
        acc_next     = acc_reg;
        sum_next     = sum_reg;
        prod_next    = prod_reg;
        neg_next     = neg_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        thrust_next  = thrust_reg;
        limited_next = limited_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    pos_t_next  = s_position_target;
                    vel_next    = s_velocity_target;
                    pos_m_next  = s_position_measured;
                    vel_m_next  = s_velocity_measured;
                    acc_ff_next = s_accel_feedforward;
                    tilt_next   = s_tilt_cosine;
                    dt_next     = s_time_step;
                    state_next  = ST_ZERR;
                end
            end
            ST_ZERR: begin
                zerr_next = add_y;
                acc_next  = '0;
                if (vel_reg < lo_v) begin
                    vel_next = lo_v;
                end else if (vel_reg > hi_v) begin
                    vel_next = hi_v;
                end
                state_next = ST_VERR;
            end
            ST_VERR: begin
                verr_next  = add_y;
                prod_next  = mul_y;
                neg_next   = mul_neg;
                state_next = ST_MUL_D;
            end
            ST_MUL_D: begin
                acc_next   = add_y;
                prod_next  = mul_y;
                neg_next   = mul_neg;
                state_next = ST_MUL_I;
            end
            ST_MUL_I: begin
                acc_next   = add_y;
                prod_next  = mul_y;
                neg_next   = mul_neg;
                state_next = ST_ADD_FF;
            end
            ST_ADD_FF: begin
                acc_next   = add_y;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                sum_next   = add_y;
                state_next = ST_MUL_G;
            end
            ST_MUL_G: begin
                prod_next  = mul_y;
                neg_next   = mul_neg;
                state_next = ST_ADD_I;
            end
            ST_ADD_I: begin
                acc_next   = add_y;
                state_next = ST_GRAV;
            end
            ST_GRAV: begin
                acc_next   = add_y;
                state_next = ST_NEG;
            end
            ST_NEG: begin
                acc_next   = add_y;
                state_next = ST_MUL_M;
            end
            ST_MUL_M: begin
                prod_next  = mul_y;
                neg_next   = mul_neg;
                rem_next   = '0;
                cnt_next   = '0;
                state_next = tilt_nonpos ? ST_DONE : ST_DIV;
            end
            ST_DIV: begin
                prod_next = {prod_reg[PROD_WIDTH-3:0], qb1, qb2};
                rem_next  = r2;
                cnt_next  = cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    thrust_next  = res_thrust;
                    limited_next = res_limited;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_t_reg   <= pos_t_next;
        vel_reg     <= vel_next;
        pos_m_reg   <= pos_m_next;
        vel_m_reg   <= vel_m_next;
        acc_ff_reg  <= acc_ff_next;
        tilt_reg    <= tilt_next;
        dt_reg      <= dt_next;
        zerr_reg    <= zerr_next;
        verr_reg    <= verr_next;
        acc_reg     <= acc_next;
        prod_reg    <= prod_next;
        neg_reg     <= neg_next;
        rem_reg     <= rem_next;
        cnt_reg     <= cnt_next;
        thrust_reg  <= thrust_next;
        limited_reg <= limited_next;
    end

endmodule

`default_nettype wire
